// ===== hw/rtl/dq_pkg.sv =====
`default_nettype none

package dq_pkg;

  localparam int DQ_DEPTH = 16;
  localparam int DQ_WW    = 32;

  // request kinds
  localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [2:0] KIND_PUSH_REAR  = 3'd1;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [2:0] KIND_POP_REAR   = 3'd3;
  localparam logic [2:0] KIND_LIST       = 3'd4;

  // response status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // cell update modes
  localparam logic [1:0] MODE_HOLD       = 2'd0;
  localparam logic [1:0] MODE_FROM_LEFT  = 2'd1;
  localparam logic [1:0] MODE_FROM_RIGHT = 2'd2;
  localparam logic [1:0] MODE_LOAD       = 2'd3;

  typedef struct packed {
    logic        [2:0]       kind;
    logic signed [DQ_WW-1:0] value;
  } req_t;

  typedef struct packed {
    logic        [1:0]       status;
    logic signed [DQ_WW-1:0] value_res;
    logic                    last;
  } rsp_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [DQ_WW-1:0] load_word;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/double_ended_queue.sv =====
// double-ended queue of signed 32-bit words, held in a row of cells
// request channel: req_valid / req_stall carry one req_t beat (kind, value)
// response channel: rsp_valid / rsp_stall carry one rsp_t beat (status,
//   value_res, last)
// cell 0 is always the front; cells shift toward the rear on push front and
//   toward the front on pop front, so no head pointer is needed
// push front, push rear, pop front, pop rear: one response, registered, on
//   the cycle after the request beat; one request per cycle when unstalled
// list: the row rotates one cell per cycle unless the response stalls;
//   cell 0 goes out as a response and re-enters at the rear; the request
//   port stalls meanwhile; an empty list gives one empty response
// unused kind codes are dropped with no response
// reset clears the count, the list sequencer and the response valid;
//   cell contents are not cleared
// a stalled response holds its register, and the request port stalls until
//   the response register can take a new beat
`default_nettype none

module double_ended_queue #(
  parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         req_valid,
  output logic              req_stall,
  input  wire dq_pkg::req_t req,
  output logic              rsp_valid,
  input  wire logic         rsp_stall,
  output dq_pkg::rsp_t      rsp
);
  import dq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  // control state
  logic [CW-1:0] count, count_next;
  logic          listing, listing_next;
  logic [CW-1:0] left_cnt, left_cnt_next;
  logic          rsp_valid_next;
  rsp_t          rsp_next;

  logic [DQ_WW-1:0] words [DEPTH];
  cell_ctl_t        ctls  [DEPTH];

  logic          slot_free, accept, rotate, full, empty;
  logic [IW-1:0] rear_idx;

  assign slot_free = !rsp_valid || !rsp_stall;
  assign req_stall = listing || !slot_free;
  assign accept    = req_valid && !req_stall;
  assign rotate    = listing && slot_free;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign rear_idx  = IW'(count - CW'(1));

  // sequencer and response
  always_comb begin
    count_next     = count;
    listing_next   = listing;
    left_cnt_next  = left_cnt;
    rsp_valid_next = rsp_valid;
    rsp_next       = rsp;
    if (slot_free) begin
      rsp_valid_next = 1'b0;
    end
    if (accept) begin
      rsp_next.status    = ST_OK;
      rsp_next.value_res = '0;
      rsp_next.last      = 1'b1;
      case (req.kind)
        KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
          rsp_valid_next = 1'b1;
          if (full) begin
            rsp_next.status = ST_FULL;
          end else begin
            count_next = count + CW'(1);
          end
        end
        KIND_POP_FRONT: begin
          rsp_valid_next = 1'b1;
          if (empty) begin
            rsp_next.status = ST_EMPTY;
          end else begin
            rsp_next.value_res = $signed(words[0]);
            count_next         = count - CW'(1);
          end
        end
        KIND_POP_REAR: begin
          rsp_valid_next = 1'b1;
          if (empty) begin
            rsp_next.status = ST_EMPTY;
          end else begin
            rsp_next.value_res = $signed(words[rear_idx]);
            count_next         = count - CW'(1);
          end
        end
        KIND_LIST: begin
          if (empty) begin
            rsp_valid_next  = 1'b1;
            rsp_next.status = ST_EMPTY;
          end else begin
            listing_next  = 1'b1;
            left_cnt_next = count;
          end
        end
        default: begin
          // unused kind, no response
        end
      endcase
    end
    if (rotate) begin
      // front cell goes out, the row rotates under it
      rsp_valid_next     = 1'b1;
      rsp_next.status    = ST_OK;
      rsp_next.value_res = $signed(words[0]);
      rsp_next.last      = (left_cnt == CW'(1));
      left_cnt_next      = left_cnt - CW'(1);
      if (left_cnt == CW'(1)) begin
        listing_next = 1'b0;
      end
    end
  end

  // per-cell update modes
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctls[i].mode      = MODE_HOLD;
      ctls[i].load_word = rotate ? words[0] : $unsigned(req.value);
      if (rotate) begin
        if (CW'(i) == count - CW'(1)) begin
          ctls[i].mode = MODE_LOAD;
        end else if (CW'(i) < count) begin
          ctls[i].mode = MODE_FROM_RIGHT;
        end
      end else if (accept) begin
        case (req.kind)
          KIND_PUSH_FRONT: begin
            if (!full) begin
              ctls[i].mode = (i == 0) ? MODE_LOAD : MODE_FROM_LEFT;
            end
          end
          KIND_PUSH_REAR: begin
            if (!full && CW'(i) == count) begin
              ctls[i].mode = MODE_LOAD;
            end
          end
          KIND_POP_FRONT: begin
            if (!empty) begin
              ctls[i].mode = MODE_FROM_RIGHT;
            end
          end
          default: begin
            ctls[i].mode = MODE_HOLD;
          end
        endcase
      end
    end
  end

  // the row of cells, each linked to both neighbors
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DQ_WW-1:0] lw, rw;
    if (g == 0) begin : g_first
      assign lw = '0;
    end else begin : g_mid_l
      assign lw = words[g-1];
    end
    if (g == DEPTH - 1) begin : g_lastc
      assign rw = '0;
    end else begin : g_mid_r
      assign rw = words[g+1];
    end
    dq_cell u_cell (
      .clk        (clk),
      .ctl        (ctls[g]),
      .left_word  (lw),
      .right_word (rw),
      .word       (words[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      listing   <= 1'b0;
      left_cnt  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count     <= count_next;
      listing   <= listing_next;
      left_cnt  <= left_cnt_next;
      rsp_valid <= rsp_valid_next;
    end
    rsp <= rsp_next;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dq_cell.sv =====
`default_nettype none

module dq_cell (
  input  wire logic                     clk,
  input  wire dq_pkg::cell_ctl_t        ctl,
  input  wire logic [dq_pkg::DQ_WW-1:0] left_word,
  input  wire logic [dq_pkg::DQ_WW-1:0] right_word,
  output logic      [dq_pkg::DQ_WW-1:0] word
);
  import dq_pkg::*;

  logic [DQ_WW-1:0] word_next;

  always_comb begin
    case (ctl.mode)
      MODE_HOLD:       word_next = word;
      MODE_FROM_LEFT:  word_next = left_word;
      MODE_FROM_RIGHT: word_next = right_word;
      MODE_LOAD:       word_next = ctl.load_word;
      default:         word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

`default_nettype wire
